// ----- rtl/tcd_pkg.sv -----
// Package for the text command decoder: word types, character and command codes,
// and the table of command words.
// No dependencies; used by the store cell, the top level and the testbench.
package tcd_pkg;

    localparam int MAX_CHARS_DEFAULT = 7;

    localparam int WORD_COUNT   = 13;
    localparam int WORD_MAX_LEN = 6;
    localparam int DRIVE_WORDS  = 12;

    typedef logic [7:0] char_t;
    typedef logic [3:0] code_t;
    typedef logic [5:0] drive_t;

    localparam char_t CHAR_LF  = 8'h0A;
    localparam char_t CHAR_TAB = 8'h09;
    localparam char_t CHAR_SP  = 8'h20;
    localparam char_t CHAR_CR  = 8'h0D;

    localparam code_t CODE_NONE    = 4'd0;
    localparam code_t CODE_VERSION = 4'd13;
    localparam code_t CODE_UNKNOWN = 4'd14;

    // Words are right-aligned: the last character of a word sits in bits [7:0],
    // which matches the store chain where cell 0 holds the newest character.
    localparam logic [8*WORD_MAX_LEN-1:0] WORD_TEXT [WORD_COUNT] = '{
        48'("sv1on"), 48'("sv1off"), 48'("sv2on"), 48'("sv2off"),
        48'("sv3on"), 48'("sv3off"), 48'("sv4on"), 48'("sv4off"),
        48'("sv5on"), 48'("sv5off"), 48'("mixon"), 48'("mixoff"),
        48'("ver")
    };

    localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{
        4'd5, 4'd6, 4'd5, 4'd6, 4'd5, 4'd6, 4'd5, 4'd6, 4'd5, 4'd6, 4'd5, 4'd6, 4'd3
    };

    typedef struct packed {
        char_t  echo_char;
        logic   command_done;
        code_t  command_code;
        drive_t drive_bits;
    } result_t;

endpackage

// ----- rtl/tcd_stream_if.sv -----
// Valid/ready stream interface carrying one word of a given payload type.
// Depends on nothing; payload types come from tcd_pkg at the point of use.
interface tcd_stream_if #(parameter type payload_t = logic [7:0]);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/tcd_cell.sv -----
// One cell of the command store chain: holds one character and compares it
// against the command words at its position. Depends on tcd_pkg.
module tcd_cell
    import tcd_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic                  clk,
    input  logic                  shift_en,
    input  char_t                 prev_char,
    output char_t                 char_out,
    output logic [WORD_COUNT-1:0] word_hit
);

    char_t char_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            char_reg <= prev_char;
        end
    end

    assign char_out = char_reg;

    // Positions at or beyond a word's length do not take part in its compare.
    generate
        for (genvar w = 0; w < WORD_COUNT; w++)
        begin : g_word
            if (IDX < WORD_MAX_LEN)
            begin : g_cmp
                assign word_hit[w] = (IDX >= int'(WORD_LEN[w])) ||
                                     (char_reg == WORD_TEXT[w][IDX*8 +: 8]);
            end
            else
            begin : g_pass
                assign word_hit[w] = 1'b1;
            end
        end
    endgenerate

endmodule

// ----- rtl/text_command_decoder.sv -----
// Text command decoder: echoes each character, collects command characters in a
// chain of store cells and decodes a finished command into valve and mixer bits.
// Each accepted character's result word is registered and offered in the next cycle.
// One character per cycle unless results stall, set by the single output register.
// Reset: count cleared, all drive bits off, no result pending; store contents undefined.
// Depends on tcd_pkg, tcd_stream_if and tcd_cell.
module text_command_decoder
    import tcd_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    tcd_stream_if.sink   chars,
    tcd_stream_if.source results
);

    localparam int CW = $clog2(MAX_CHARS + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    drive_t        drive_reg;
    drive_t        drive_next;
    logic          out_valid_reg;
    result_t       out_reg;
    result_t       out_next;

    logic          accept;
    char_t         c;
    logic          is_ignored;
    logic          is_cr;
    logic          store_en;

    char_t                 cell_char [MAX_CHARS];
    logic [WORD_COUNT-1:0] cell_hit  [MAX_CHARS];
    logic [WORD_COUNT-1:0] word_hit;
    code_t                 code_match;
    drive_t                drive_cmd;

    assign c          = chars.payload;
    assign chars.ready = !out_valid_reg || results.ready;
    assign accept     = chars.valid && chars.ready;
    assign is_ignored = (c == CHAR_LF) || (c == CHAR_SP) || (c == CHAR_TAB);
    assign is_cr      = (c == CHAR_CR);
    assign store_en   = accept && !is_ignored && !is_cr;

    generate
        for (genvar k = 0; k < MAX_CHARS; k++)
        begin : g_cell
            tcd_cell #(
                .IDX (k)
            ) u_cell (
                .clk       (clk),
                .shift_en  (store_en),
                .prev_char ((k == 0) ? c : cell_char[(k == 0) ? 0 : k - 1]),
                .char_out  (cell_char[k]),
                .word_hit  (cell_hit[k])
            );
        end
    endgenerate

    // A word matches when every cell agrees and the stored length equals its length.
    always_comb
    begin
        for (int w = 0; w < WORD_COUNT; w++)
        begin
            word_hit[w] = (count_reg == CW'(WORD_LEN[w]));
        end
        for (int k = 0; k < MAX_CHARS; k++)
        begin
            word_hit = word_hit & cell_hit[k];
        end
    end

    always_comb
    begin
        code_match = CODE_UNKNOWN;
        for (int w = WORD_COUNT - 1; w >= 0; w--)
        begin
            if (word_hit[w])
            begin
                code_match = code_t'(w + 1);
            end
        end
        drive_cmd = drive_reg;
        for (int w = 0; w < DRIVE_WORDS; w++)
        begin
            if (word_hit[w])
            begin
                drive_cmd[w >> 1] = ((w & 1) == 0);
            end
        end
    end

    always_comb
    begin
        count_next             = count_reg;
        drive_next             = drive_reg;
        out_next.echo_char     = c;
        out_next.command_done  = 1'b0;
        out_next.command_code  = CODE_NONE;
        priority if (is_ignored)
        begin
            count_next = count_reg;
        end
        else if (is_cr)
        begin
            count_next            = '0;
            drive_next            = drive_cmd;
            out_next.command_done = 1'b1;
            out_next.command_code = code_match;
        end
        else if (count_reg == CW'(MAX_CHARS))
        begin
            count_next            = '0;
            out_next.command_done = 1'b1;
            out_next.command_code = CODE_UNKNOWN;
        end
        else
        begin
            count_next = count_reg + 1'b1;
        end
        out_next.drive_bits = drive_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drive_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                drive_reg     <= drive_next;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_reg;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for text_command_decoder: drives characters on the chars stream,
// predicts each result word, and checks it field by field on the results stream.
// Depends on tcd_pkg, tcd_stream_if and the text_command_decoder RTL.
`timescale 1ns / 100ps

module testbench;
    import tcd_pkg::*;

    localparam int MAX_CMD_CHARS = MAX_CHARS_DEFAULT;
    localparam int STORE_DEPTH   = MAX_CMD_CHARS + 1;
    localparam int RANDOM_CHARS  = 1080;
    localparam int PHASE_CHARS   = RANDOM_CHARS / 3;
    localparam int HOLD_CYCLES   = 250;

    localparam code_t CMD_SV1_ON  = 4'd1;
    localparam code_t CMD_SV1_OFF = 4'd2;
    localparam code_t CMD_SV2_ON  = 4'd3;
    localparam code_t CMD_SV2_OFF = 4'd4;
    localparam code_t CMD_SV3_ON  = 4'd5;
    localparam code_t CMD_SV3_OFF = 4'd6;
    localparam code_t CMD_SV4_ON  = 4'd7;
    localparam code_t CMD_SV4_OFF = 4'd8;
    localparam code_t CMD_SV5_ON  = 4'd9;
    localparam code_t CMD_SV5_OFF = 4'd10;
    localparam code_t CMD_MIX_ON  = 4'd11;
    localparam code_t CMD_MIX_OFF = 4'd12;

    localparam drive_t DRIVE_OFF = '0;
    localparam char_t  LOWER_A   = "a";
    localparam char_t  LOWER_Z   = "z";

    string word_text [WORD_COUNT] = '{
        "sv1on", "sv1off", "sv2on", "sv2off", "sv3on", "sv3off", "sv4on", "sv4off",
        "sv5on", "sv5off", "mixon", "mixoff", "ver"
    };
    code_t word_code [WORD_COUNT] = '{
        CMD_SV1_ON, CMD_SV1_OFF, CMD_SV2_ON, CMD_SV2_OFF, CMD_SV3_ON, CMD_SV3_OFF,
        CMD_SV4_ON, CMD_SV4_OFF, CMD_SV5_ON, CMD_SV5_OFF, CMD_MIX_ON, CMD_MIX_OFF,
        CODE_VERSION
    };

    typedef struct packed {
        char_t  ch;
        logic   typed;
        logic   done;
        code_t  code;
        drive_t drive;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 24;

    // Rows with typed set carry their expected word; all others come from the predictor.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CHAR_CR,  1'b1, 1'b1, CODE_UNKNOWN, DRIVE_OFF},
        '{8'h00,    1'b1, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{CHAR_CR,  1'b1, 1'b1, CODE_UNKNOWN, DRIVE_OFF},
        '{"v",      1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{CHAR_SP,  1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{"e",      1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{CHAR_TAB, 1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{"r",      1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{CHAR_LF,  1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{CHAR_CR,  1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{"s",      1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{"v",      1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{"1",      1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{"o",      1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{"n",      1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{CHAR_CR,  1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{8'hFF,    1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{8'hFF,    1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{8'hFF,    1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{8'hFF,    1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{8'hFF,    1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{8'hFF,    1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{8'hFF,    1'b0, 1'b0, CODE_NONE,    DRIVE_OFF},
        '{8'hFF,    1'b1, 1'b1, CODE_UNKNOWN, 6'b000001}
    };

    logic clk;
    logic rst_n;

    tcd_stream_if #(.payload_t(char_t))   chars_if ();
    tcd_stream_if #(.payload_t(result_t)) results_if ();

    text_command_decoder uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    // Predictor state.
    char_t  cmd_store [STORE_DEPTH];
    int     cmd_len = 0;
    drive_t drive_state = DRIVE_OFF;

    result_t pending_results [$];
    int      mismatch_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_left = 0;
    int      chars_in_phase = 0;
    int      next_word = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit is_blank(char_t c);
        return c == CHAR_LF || c == CHAR_SP || c == CHAR_TAB;
    endfunction

    function automatic code_t lookup_command();
        bit same;
        for (int w = 0; w < WORD_COUNT; w++)
        begin
            same = (word_text[w].len() == cmd_len);
            for (int i = 0; same && i < cmd_len; i++)
                if (cmd_store[i] != char_t'(word_text[w][i]))
                    same = 1'b0;
            if (same)
                return word_code[w];
        end
        return CODE_UNKNOWN;
    endfunction

    function automatic result_t decode_char(char_t c);
        result_t r;
        int      offset;
        r.echo_char    = c;
        r.command_done = 1'b0;
        r.command_code = CODE_NONE;
        if (c == CHAR_CR)
        begin
            r.command_code = lookup_command();
            r.command_done = 1'b1;
            // Valve and mixer words come in on/off pairs; each pair owns one drive bit.
            if (r.command_code >= CMD_SV1_ON && r.command_code <= CMD_MIX_OFF)
            begin
                offset = r.command_code - CMD_SV1_ON;
                drive_state[offset / 2] = (offset % 2 == 0);
            end
            cmd_len = 0;
        end
        else if (!is_blank(c))
        begin
            cmd_store[cmd_len] = c;
            cmd_len++;
            if (cmd_len > MAX_CMD_CHARS)
            begin
                cmd_len = 0;
                r.command_code = CODE_UNKNOWN;
                r.command_done = 1'b1;
            end
        end
        r.drive_bits = drive_state;
        return r;
    endfunction

    function automatic char_t random_blank();
        case ($urandom_range(2))
            0: return CHAR_SP;
            1: return CHAR_TAB;
            default: return CHAR_LF;
        endcase
    endfunction

    task automatic compare_field(string name, logic [7:0] expected, logic [7:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            mismatch_count++;
        end
    endtask

    task automatic check_result(result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result word: echo_char %0d", got.echo_char);
            mismatch_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            compare_field("echo_char", want.echo_char, got.echo_char);
            compare_field("command_done", 8'(want.command_done), 8'(got.command_done));
            compare_field("command_code", 8'(want.command_code), 8'(got.command_code));
            compare_field("drive_bits", 8'(want.drive_bits), 8'(got.drive_bits));
        end
    endtask

    // Offers one character and returns at the edge where it is accepted.
    task automatic offer_char(char_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid   <= 1'b1;
        chars_if.payload <= c;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
    endtask

    task automatic wait_all_results();
        chars_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_command();
        char_t seq [$];
        int    kind;
        int    w;
        int    pos;
        int    n;
        kind = $urandom_range(99);
        if (kind < 72)
        begin
            // Word, garbled if kind >= 60; first thirteen clean ones walk all words once.
            if (kind < 60 && next_word < WORD_COUNT)
            begin
                w = next_word;
                next_word++;
            end
            else
                w = $urandom_range(WORD_COUNT - 1);
            for (int i = 0; i < word_text[w].len(); i++)
            begin
                if ($urandom_range(99) < 15)
                    seq.push_back(random_blank());
                seq.push_back(char_t'(word_text[w][i]));
            end
            if (kind >= 60)
            begin
                pos = $urandom_range(seq.size() - 1);
                case ($urandom_range(2))
                    0: seq.delete(pos);
                    1: seq[pos] = char_t'($urandom_range(255));
                    default: seq.insert(pos, char_t'($urandom_range(LOWER_Z, LOWER_A)));
                endcase
            end
        end
        else if (kind < 87)
        begin
            n = $urandom_range(9);
            repeat (n)
                seq.push_back(char_t'($urandom_range(255)));
        end
        else
        begin
            n = $urandom_range(MAX_CMD_CHARS + 4, MAX_CMD_CHARS + 1);
            repeat (n)
                seq.push_back(char_t'($urandom_range(LOWER_Z, LOWER_A)));
        end
        seq.push_back(CHAR_CR);
        foreach (seq[i])
        begin
            offer_char(seq[i]);
            pending_results.push_back(decode_char(seq[i]));
            if (!is_blank(seq[i]))
                chars_in_phase++;
        end
    endtask

    // Result side: checks each accepted word and sets ready for the next edge.
    initial
    begin
        results_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (results_if.valid && results_if.ready)
                check_result(results_if.payload);
            if (hold_left > 0)
            begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else
                results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        result_t want;
        rst_n            = 1'b0;
        chars_if.valid   = 1'b0;
        chars_if.payload = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            offer_char(directed_rows[i].ch);
            want = decode_char(directed_rows[i].ch);
            if (directed_rows[i].typed)
                want = '{directed_rows[i].ch, directed_rows[i].done,
                         directed_rows[i].code, directed_rows[i].drive};
            pending_results.push_back(want);
        end
        wait_all_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct = 65;
                end
                1:
                begin
                    send_idle_pct = 65;
                    recv_idle_pct = 32;
                    // The sender keeps offering while the result side is held off.
                    hold_left = HOLD_CYCLES;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            chars_in_phase = 0;
            while (chars_in_phase < PHASE_CHARS)
                send_command();
            if (phase == 0)
                wait_all_results();
        end

        wait_all_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tcd_pkg.sv
rtl/tcd_stream_if.sv
rtl/tcd_cell.sv
rtl/text_command_decoder.sv
verif/testbench.sv
